// ----- rtl/core/aroc_pkg.sv -----
// shared types and constants for the audio ring offset controller
// no dependencies; imported by every module of the block
package aroc_pkg;

   localparam int DEF_OFFSET_BITS   = 32;
   localparam int DEF_RING_LOG2_MAX = 24;

   localparam int COUNT_W   = 24;
   localparam int FRAMES_W  = 25;
   localparam int PLAYED_W  = 32;
   localparam int LOG2_W    = 5;
   localparam int SHIFT_W   = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 24;
   // count shifted by the largest frame shift
   localparam int BYTES_W   = COUNT_W + 4;

   localparam logic [LOG2_W-1:0]  RING_LOG2_MIN   = 5'd12;
   localparam logic [SHIFT_W-1:0] FRAME_SHIFT_MAX = 3'd4;

   localparam logic [LOG2_W-1:0]  RING_LOG2_RESET   = 5'd16;
   localparam logic [COUNT_W-1:0] DEV_BUF_RESET     = 24'd8192;
   localparam logic [SHIFT_W-1:0] FRAME_SHIFT_RESET = 3'd3;

   typedef enum logic [1:0] {
      FUNC_LOCK    = 2'd0,
      FUNC_COMMIT  = 2'd1,
      FUNC_CLAIM   = 2'd2,
      FUNC_RELEASE = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RING_LOG2   = 2'd0,
      CSR_DEV_BUF     = 2'd1,
      CSR_FRAME_SHIFT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [LOG2_W-1:0]  ring_log2;
      logic [COUNT_W-1:0] device_buffer_bytes;
      logic [SHIFT_W-1:0] frame_shift;
   } cfg_type;

   typedef struct packed {
      func_type           func;
      logic [COUNT_W-1:0] frame_count;
   } req_item_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  position;
      logic [FRAMES_W-1:0] frames;
      logic [PLAYED_W-1:0] played_frames;
      logic [COUNT_W-1:0]  submit_frames;
      logic                silent;
      logic                overflow;
   } rsp_item_type;

endpackage

// ----- rtl/core/aroc_csr.sv -----
// configuration registers of the audio ring offset controller
// depends on aroc_pkg
module aroc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [aroc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [aroc_pkg::CSR_DAT_W-1:0] csr_data,
   output aroc_pkg::cfg_type              cfg
);
   import aroc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_RING_LOG2:   cfg_in.ring_log2 = csr_data[LOG2_W-1:0];
            CSR_DEV_BUF:     cfg_in.device_buffer_bytes = csr_data[COUNT_W-1:0];
            CSR_FRAME_SHIFT: cfg_in.frame_shift = csr_data[SHIFT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ring_log2           <= RING_LOG2_RESET;
         cfg_ff.device_buffer_bytes <= DEV_BUF_RESET;
         cfg_ff.frame_shift         <= FRAME_SHIFT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/aroc_in_reg.sv -----
// input register: holds one command beat until the datapath takes it
// depends on aroc_pkg
module aroc_in_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  aroc_pkg::req_item_type in_item,
   output logic                   hold_valid,
   output aroc_pkg::req_item_type hold_item,
   input  logic                   take
);
   import aroc_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   assign in_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

endmodule

// ----- rtl/core/aroc_exec.sv -----
// offset state and single-pass command datapath (lock, commit, claim, release)
// depends on aroc_pkg
module aroc_exec #(
   parameter int OFFSET_BITS   = aroc_pkg::DEF_OFFSET_BITS,
   parameter int RING_LOG2_MAX = aroc_pkg::DEF_RING_LOG2_MAX
) (
   input  logic                   clock,
   input  logic                   reset,
   input  aroc_pkg::cfg_type      cfg,
   input  logic                   step,
   input  aroc_pkg::req_item_type item,
   output aroc_pkg::rsp_item_type result
);
   import aroc_pkg::*;

   localparam int OB = OFFSET_BITS;
   localparam int CW = (OB > BYTES_W) ? OB : BYTES_W;
   localparam int LMAX_I = (RING_LOG2_MAX < OB - 1) ? RING_LOG2_MAX : OB - 1;
   localparam logic [LOG2_W-1:0] LOG2_TOP = LOG2_W'(LMAX_I);

   logic [OB-1:0]       read_ff, read_in;
   logic [OB-1:0]       write_ff, write_in;
   logic [OB-1:0]       lock_ff, lock_in;
   logic [PLAYED_W-1:0] submitted_ff, submitted_in;
   logic                first_ff, first_in;
   logic [OB-1:0]       claimed_ff, claimed_in;
   logic [OB-1:0]       grant_left_ff, grant_left_in;

   logic [LOG2_W-1:0]  log2_eff;
   logic [SHIFT_W-1:0] sh;
   logic [OB-1:0]      ring, ring_mask;
   logic [OB-1:0]      avail, used_raw, used, dbb, new_lock, grant;
   logic [CW-1:0]      bytes_req, grant_cmp;
   logic [OB-1:0]      bytes_ok, grant_floor;
   logic [OB-1:0]      avail_frames;
   logic [COUNT_W-1:0] use_frames, sub_frames;
   logic [OB-1:0]      use_bytes;

   always_comb begin
      log2_eff = cfg.ring_log2;
      if (log2_eff < RING_LOG2_MIN) begin
         log2_eff = RING_LOG2_MIN;
      end
      if (log2_eff > LOG2_TOP) begin
         log2_eff = LOG2_TOP;
      end
      sh = (cfg.frame_shift > FRAME_SHIFT_MAX) ? FRAME_SHIFT_MAX : cfg.frame_shift;
      ring      = OB'(1) << log2_eff;
      ring_mask = ring - OB'(1);
   end

   // lock: keep one device buffer reserved beyond the read offset
   always_comb begin
      dbb      = OB'(cfg.device_buffer_bytes);
      avail    = write_ff - read_ff;
      used_raw = lock_ff - read_ff;
      used     = used_raw;
      new_lock = lock_ff;
      if (used_raw < dbb) begin
         used     = (dbb < avail) ? dbb : avail;
         new_lock = read_ff + used;
      end
      grant = (used < ring) ? ring - used : '0;
   end

   // commit: clamp to whole frames of what is left of the grant
   always_comb begin
      bytes_req   = CW'(item.frame_count) << sh;
      grant_cmp   = CW'(grant_left_ff);
      grant_floor = (grant_left_ff >> sh) << sh;
      bytes_ok    = OB'(bytes_req);
   end

   // claim
   always_comb begin
      avail_frames = avail >> sh;
      use_frames   = (avail_frames < OB'(item.frame_count)) ?
                     avail_frames[COUNT_W-1:0] : item.frame_count;
      use_bytes    = OB'(BYTES_W'(use_frames) << sh);
      sub_frames   = (use_frames != '0) ? use_frames : item.frame_count;
   end

   always_comb begin
      read_in       = read_ff;
      write_in      = write_ff;
      lock_in       = lock_ff;
      submitted_in  = submitted_ff;
      first_in      = first_ff;
      claimed_in    = claimed_ff;
      grant_left_in = grant_left_ff;
      result        = '0;
      case (item.func)
         FUNC_LOCK: begin
            lock_in              = new_lock;
            write_in             = new_lock;
            first_in             = 1'b0;
            submitted_in         = '0;
            grant_left_in        = grant;
            result.played_frames = first_ff ? '0 : submitted_ff;
            result.position      = COUNT_W'(new_lock & ring_mask);
            result.frames        = FRAMES_W'(grant >> sh);
         end
         FUNC_COMMIT: begin
            if (bytes_req > grant_cmp) begin
               write_in        = write_ff + grant_floor;
               grant_left_in   = grant_left_ff - grant_floor;
               result.overflow = 1'b1;
            end else begin
               write_in      = write_ff + bytes_ok;
               grant_left_in = grant_left_ff - bytes_ok;
            end
         end
         FUNC_CLAIM: begin
            lock_in              = read_ff + use_bytes;
            submitted_in         = submitted_ff + PLAYED_W'(sub_frames);
            claimed_in           = use_bytes;
            result.position      = COUNT_W'(read_ff & ring_mask);
            result.frames        = FRAMES_W'(use_frames);
            result.submit_frames = sub_frames;
            result.silent        = (use_frames == '0);
         end
         FUNC_RELEASE: begin
            read_in    = read_ff + claimed_ff;
            claimed_in = '0;
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_ff       <= '0;
         write_ff      <= '0;
         lock_ff       <= '0;
         submitted_ff  <= '0;
         first_ff      <= 1'b1;
         claimed_ff    <= '0;
         grant_left_ff <= '0;
      end else if (step) begin
         read_ff       <= read_in;
         write_ff      <= write_in;
         lock_ff       <= lock_in;
         submitted_ff  <= submitted_in;
         first_ff      <= first_in;
         claimed_ff    <= claimed_in;
         grant_left_ff <= grant_left_in;
      end
   end

endmodule

// ----- rtl/core/aroc_out_reg.sv -----
// result register: holds one result beat until the consumer takes it
// depends on aroc_pkg
module aroc_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  aroc_pkg::rsp_item_type load_item,
   output logic                   can_load,
   output logic                   out_valid,
   input  logic                   out_ready,
   output aroc_pkg::rsp_item_type out_item
);
   import aroc_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign can_load = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (can_load) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && can_load) begin
         item_ff <= load_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ----- rtl/core/audio_ring_offset_controller_top.sv -----
// Audio ring offset controller. Each command beat on req_ passes an input
// register, is executed in one pass against the registered read, write and
// lock offsets, and its single result beat leaves from a result register on
// rsp_. One command is taken every clock cycle while the result side drains;
// the command waits in the input register until the result register can take
// its result beat. The rate is set by the offset state update, which each
// command must finish before the next one reads it. Configuration writes on
// csr_ are always accepted and take effect on the next command.
// depends on aroc_pkg, aroc_csr, aroc_in_reg, aroc_exec, aroc_out_reg
module audio_ring_offset_controller_top #(
   parameter int OFFSET_BITS   = aroc_pkg::DEF_OFFSET_BITS,
   parameter int RING_LOG2_MAX = aroc_pkg::DEF_RING_LOG2_MAX
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [23:0]                    req_tdata,  // frame_count
   input  logic [1:0]                     req_tuser,  // func
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // position, frames, played_frames, submit_frames, zero pad
   output logic [111:0]                   rsp_tdata,
   output logic [1:0]                     rsp_tuser,  // silent, overflow
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [aroc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [aroc_pkg::CSR_DAT_W-1:0] csr_data
);
   import aroc_pkg::*;

   cfg_type      cfg;
   req_item_type req_item, hold_item;
   rsp_item_type result, out_item;
   logic         hold_valid, can_load, step;

   aroc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign req_item.func        = func_type'(req_tuser);
   assign req_item.frame_count = req_tdata;

   aroc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .hold_valid (hold_valid),
      .hold_item  (hold_item),
      .take       (step)
   );

   assign step = hold_valid && can_load;

   aroc_exec #(
      .OFFSET_BITS   (OFFSET_BITS),
      .RING_LOG2_MAX (RING_LOG2_MAX)
   ) u_exec (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (step),
      .item   (hold_item),
      .result (result)
   );

   aroc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (hold_valid),
      .load_item (result),
      .can_load  (can_load),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {7'd0, out_item.submit_frames, out_item.played_frames,
                       out_item.frames, out_item.position};
   assign rsp_tuser = {out_item.overflow, out_item.silent};

endmodule

// ----- bench/audio_ring_offset_controller_top_test.sv -----
// self-checking bench for audio_ring_offset_controller_top: directed command table, then
// random lock/commit/claim/release sequences checked against a local offset predictor
// depends on aroc_pkg and the rtl of audio_ring_offset_controller_top
module audio_ring_offset_controller_top_test;
   import aroc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int N_DIRECTED  = 23;
   localparam int N_PHASES    = 8;

   typedef struct packed {
      req_item_type cmd;
      logic         typed;
      rsp_item_type exp;
   } row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [23:0]          req_tdata = '0;
   logic [1:0]           req_tuser = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [111:0]         rsp_tdata;
   logic [1:0]           rsp_tuser;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   audio_ring_offset_controller_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the configuration and offset state
   logic [LOG2_W-1:0]  cfg_log2  = RING_LOG2_RESET;
   logic [COUNT_W-1:0] cfg_devbuf = DEV_BUF_RESET;
   logic [SHIFT_W-1:0] cfg_shift = FRAME_SHIFT_RESET;
   logic [31:0] rd_ofs = '0;
   logic [31:0] wr_ofs = '0;
   logic [31:0] lk_ofs = '0;
   logic [31:0] played_acc = '0;
   logic [31:0] claim_bytes = '0;
   logic [31:0] grant_bytes = '0;
   logic        lock_fresh = 1'b1;

   row_type      command_queue[$];
   rsp_item_type expected_results[$];
   row_type      current_row;
   rsp_item_type predicted;
   rsp_item_type observed;
   rsp_item_type wanted;
   logic         beat_taken = 1'b0;
   int           gap_pct = 0;
   int           stall_pct = 0;
   int           n_queued = 0;
   int           n_accepted = 0;
   int           n_errors = 0;
   int           cycle_count = 0;

   row_type directed_rows [N_DIRECTED] = '{
      // commit before any lock has no grant
      '{'{FUNC_COMMIT,  24'd5},        1'b1, '{24'd0, 25'd0,    32'd0,    24'd0,    1'b0, 1'b1}},
      // release without a claim
      '{'{FUNC_RELEASE, 24'd0},        1'b1, '{24'd0, 25'd0,    32'd0,    24'd0,    1'b0, 1'b0}},
      '{'{FUNC_CLAIM,   24'd10},       1'b1, '{24'd0, 25'd0,    32'd0,    24'd10,   1'b1, 1'b0}},
      // first lock reports nothing played
      '{'{FUNC_LOCK,    24'd0},        1'b1, '{24'd0, 25'd8192, 32'd0,    24'd0,    1'b0, 1'b0}},
      '{'{FUNC_COMMIT,  24'd0},        1'b1, '{24'd0, 25'd0,    32'd0,    24'd0,    1'b0, 1'b0}},
      '{'{FUNC_COMMIT,  24'hFFFFFF},   1'b1, '{24'd0, 25'd0,    32'd0,    24'd0,    1'b0, 1'b1}},
      '{'{FUNC_CLAIM,   24'hFFFFFF},   1'b1, '{24'd0, 25'd8192, 32'd0,    24'd8192, 1'b0, 1'b0}},
      // reserved range fills the ring, nothing granted
      '{'{FUNC_LOCK,    24'hFFFFFF},   1'b1, '{24'd0, 25'd0,    32'd8192, 24'd0,    1'b0, 1'b0}},
      '{'{FUNC_COMMIT,  24'd1},        1'b1, '{24'd0, 25'd0,    32'd0,    24'd0,    1'b0, 1'b1}},
      '{'{FUNC_RELEASE, 24'd0},        1'b1, '{24'd0, 25'd0,    32'd0,    24'd0,    1'b0, 1'b0}},
      // second release frees nothing
      '{'{FUNC_RELEASE, 24'hFFFFFF},   1'b1, '{24'd0, 25'd0,    32'd0,    24'd0,    1'b0, 1'b0}},
      '{'{FUNC_CLAIM,   24'd0},        1'b1, '{24'd0, 25'd0,    32'd0,    24'd0,    1'b1, 1'b0}},
      '{'{FUNC_LOCK,    24'd0},        1'b1, '{24'd0, 25'd8192, 32'd0,    24'd0,    1'b0, 1'b0}},
      '{'{FUNC_COMMIT,  24'd100},      1'b0, '0},
      '{'{FUNC_CLAIM,   24'd30},       1'b0, '0},
      // newer claim replaces the older one
      '{'{FUNC_CLAIM,   24'd50},       1'b0, '0},
      '{'{FUNC_RELEASE, 24'd0},        1'b0, '0},
      '{'{FUNC_LOCK,    24'd0},        1'b0, '0},
      '{'{FUNC_COMMIT,  24'hAAAAAA},   1'b0, '0},
      '{'{FUNC_CLAIM,   24'h555555},   1'b0, '0},
      '{'{FUNC_RELEASE, 24'd0},        1'b0, '0},
      '{'{FUNC_LOCK,    24'd0},        1'b0, '0},
      '{'{FUNC_CLAIM,   24'h123456},   1'b0, '0}
   };

   function automatic logic [31:0] ring_span_bytes();
      logic [LOG2_W-1:0] l;
      l = cfg_log2;
      if (l < RING_LOG2_MIN) l = RING_LOG2_MIN;
      if (l > 5'(DEF_RING_LOG2_MAX)) l = 5'(DEF_RING_LOG2_MAX);
      return 32'd1 << l;
   endfunction

   function automatic logic [SHIFT_W-1:0] eff_shift();
      return (cfg_shift > FRAME_SHIFT_MAX) ? FRAME_SHIFT_MAX : cfg_shift;
   endfunction

   // advances the offset state by one command and returns its result
   function automatic rsp_item_type offset_step(req_item_type cmd);
      logic [31:0]        ring, used, avail, grant, bytes, avail_fr, take, take_bytes, sub;
      logic [31:0]        count;
      logic [SHIFT_W-1:0] sh;
      rsp_item_type       r;
      ring  = ring_span_bytes();
      sh    = eff_shift();
      count = {8'd0, cmd.frame_count};
      r     = '0;
      case (cmd.func)
         FUNC_LOCK: begin
            used = lk_ofs - rd_ofs;
            if (used < {8'd0, cfg_devbuf}) begin
               avail  = wr_ofs - rd_ofs;
               used   = ({8'd0, cfg_devbuf} < avail) ? {8'd0, cfg_devbuf} : avail;
               lk_ofs = rd_ofs + used;
            end
            grant = (used < ring) ? ring - used : 32'd0;
            wr_ofs = lk_ofs;
            r.played_frames = lock_fresh ? 32'd0 : played_acc;
            lock_fresh  = 1'b0;
            played_acc  = '0;
            grant_bytes = grant;
            r.position  = COUNT_W'(lk_ofs & (ring - 32'd1));
            r.frames    = FRAMES_W'(grant >> sh);
         end
         FUNC_COMMIT: begin
            bytes = count << sh;
            if (bytes > grant_bytes) begin
               bytes = (grant_bytes >> sh) << sh;
               r.overflow = 1'b1;
            end
            wr_ofs      = wr_ofs + bytes;
            grant_bytes = grant_bytes - bytes;
         end
         FUNC_CLAIM: begin
            avail      = wr_ofs - rd_ofs;
            avail_fr   = avail >> sh;
            take       = (avail_fr < count) ? avail_fr : count;
            take_bytes = take << sh;
            sub        = (take != 0) ? take : count;
            lk_ofs      = rd_ofs + take_bytes;
            played_acc  = played_acc + sub;
            claim_bytes = take_bytes;
            r.position      = COUNT_W'(rd_ofs & (ring - 32'd1));
            r.frames        = FRAMES_W'(take);
            r.submit_frames = COUNT_W'(sub);
            r.silent        = (take == 0);
         end
         default: begin
            rd_ofs      = rd_ofs + claim_bytes;
            claim_bytes = '0;
         end
      endcase
      return r;
   endfunction

   // frame counts either small or scaled to the current ring, now and then any 24-bit value
   function automatic logic [COUNT_W-1:0] pick_count();
      int unsigned span;
      int unsigned r;
      span = ring_span_bytes() >> eff_shift();
      if (span > 32'hFFFFFF) span = 32'hFFFFFF;
      r = $urandom_range(0, 99);
      if (r < 45) return COUNT_W'($urandom_range(0, 64));
      else if (r < 80) return COUNT_W'($urandom_range(0, span));
      else if (r < 95) return COUNT_W'($urandom_range(span / 2, span));
      else return COUNT_W'($urandom);
   endfunction

   task automatic push_cmd(func_type f, logic [COUNT_W-1:0] c);
      row_type row;
      row = '0;
      row.cmd.func = f;
      row.cmd.frame_count = c;
      command_queue.push_back(row);
      n_queued++;
   endtask

   task automatic gen_random(int n);
      int start;
      int kind;
      start = n_queued;
      while (n_queued - start < n) begin
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            // producer then consumer round with random sizes
            push_cmd(FUNC_LOCK, COUNT_W'($urandom));
            repeat ($urandom_range(1, 3)) push_cmd(FUNC_COMMIT, pick_count());
            repeat ($urandom_range(1, 2)) push_cmd(FUNC_CLAIM, pick_count());
            if ($urandom_range(0, 3) != 0) push_cmd(FUNC_RELEASE, COUNT_W'($urandom));
         end else begin
            push_cmd(func_type'($urandom_range(0, 3)),
                     (kind < 90) ? pick_count() : COUNT_W'($urandom));
         end
      end
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DAT_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_RING_LOG2:   cfg_log2   = val[LOG2_W-1:0];
         CSR_DEV_BUF:     cfg_devbuf = val;
         CSR_FRAME_SHIFT: cfg_shift  = val[SHIFT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // waits for every queued command to be taken and answered, then the pipeline latency
   task automatic drain();
      do @(negedge clock); while (n_accepted != n_queued || expected_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // command driver and result-side stalls
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      if (!req_tvalid || beat_taken) begin
         beat_taken = 1'b0;
         if (command_queue.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
            current_row = command_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= current_row.cmd.frame_count;
            req_tuser  <= current_row.cmd.func;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         predicted = offset_step(current_row.cmd);
         expected_results.push_back(current_row.typed ? current_row.exp : predicted);
         beat_taken = 1'b1;
         n_accepted++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("result beat with no command waiting");
            n_errors++;
         end else begin
            wanted = expected_results.pop_front();
            observed.position      = rsp_tdata[23:0];
            observed.frames        = rsp_tdata[48:24];
            observed.played_frames = rsp_tdata[80:49];
            observed.submit_frames = rsp_tdata[104:81];
            observed.silent        = rsp_tuser[0];
            observed.overflow      = rsp_tuser[1];
            if (observed.position != wanted.position) begin
               $error("position: expected %0d, actual %0d", wanted.position, observed.position);
               n_errors++;
            end
            if (observed.frames != wanted.frames) begin
               $error("frames: expected %0d, actual %0d", wanted.frames, observed.frames);
               n_errors++;
            end
            if (observed.played_frames != wanted.played_frames) begin
               $error("played_frames: expected %0d, actual %0d",
                      wanted.played_frames, observed.played_frames);
               n_errors++;
            end
            if (observed.submit_frames != wanted.submit_frames) begin
               $error("submit_frames: expected %0d, actual %0d",
                      wanted.submit_frames, observed.submit_frames);
               n_errors++;
            end
            if (observed.silent != wanted.silent) begin
               $error("silent: expected %0d, actual %0d", wanted.silent, observed.silent);
               n_errors++;
            end
            if (observed.overflow != wanted.overflow) begin
               $error("overflow: expected %0d, actual %0d", wanted.overflow, observed.overflow);
               n_errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      logic [LOG2_W-1:0]    new_log2;
      logic [CSR_DAT_W-1:0] new_dev;
      logic [SHIFT_W-1:0]   new_shift;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         command_queue.push_back(directed_rows[i]);
         n_queued++;
      end
      drain();

      for (int p = 0; p < N_PHASES; p++) begin
         if (p > 0) begin
            case (p)
               1: begin new_log2 = 5'd12; new_dev = 24'd0;        new_shift = 3'd0; end
               2: begin new_log2 = 5'd24; new_dev = 24'hFFFFFF;   new_shift = 3'd4; end
               // out-of-range ring size and frame shift saturate
               3: begin new_log2 = 5'd31; new_dev = 24'd1000;     new_shift = 3'd7; end
               4: begin new_log2 = 5'd3;  new_dev = 24'd5000;     new_shift = 3'd5; end
               // reserve larger than the ring
               5: begin new_log2 = 5'd20; new_dev = 24'hFFFFFF;   new_shift = 3'd1; end
               default: begin
                  new_log2  = LOG2_W'($urandom_range(0, 31));
                  new_dev   = CSR_DAT_W'($urandom) >> $urandom_range(0, 23);
                  new_shift = SHIFT_W'($urandom_range(0, 7));
               end
            endcase
            write_csr(CSR_RING_LOG2, CSR_DAT_W'(new_log2));
            write_csr(CSR_DEV_BUF, new_dev);
            write_csr(CSR_FRAME_SHIFT, CSR_DAT_W'(new_shift));
         end
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 51; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 51; end
            default: begin gap_pct = 9; stall_pct = 9; end
         endcase
         if (p == 0) begin
            // drain the ring, then pile up silent claims so the submitted count wraps
            push_cmd(FUNC_RELEASE, 24'd0);
            push_cmd(FUNC_CLAIM, 24'hFFFFFF);
            push_cmd(FUNC_RELEASE, 24'd0);
            repeat (258) push_cmd(FUNC_CLAIM, 24'hFFFFFF);
            push_cmd(FUNC_LOCK, 24'd0);
         end
         gen_random(90);
         drain();
      end

      if (n_errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
